// ----- rtl/petrc_pkg.sv -----
// petrc_pkg: shared types and constants for the pose error / target reach check
// holds the cordic arctangent table, register map codes and the tolerance bundle
// no dependencies
package petrc_pkg;

   localparam int GUARD_BITS    = 24;
   localparam int ATAN_ENTRIES  = 24;
   localparam int ZW            = 32;
   localparam int TOL_BITS      = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      CSR_X_TOL = 2'd0,
      CSR_Y_TOL = 2'd1,
      CSR_H_TOL = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TOL_BITS-1:0] x;
      logic [TOL_BITS-1:0] y;
      logic [TOL_BITS-1:0] h;
   } tol_type;

   // atan(2^-i) in 32-bit binary angle units, rounded to nearest
   function automatic logic [ZW-1:0] atan_angle(input int idx);
      logic [ZW-1:0] a;
      a = '0;
      unique case (idx)
         0:  a = 32'd536870912;
         1:  a = 32'd316933406;
         2:  a = 32'd167458907;
         3:  a = 32'd85004756;
         4:  a = 32'd42667331;
         5:  a = 32'd21354465;
         6:  a = 32'd10679838;
         7:  a = 32'd5340245;
         8:  a = 32'd2670163;
         9:  a = 32'd1335087;
         10: a = 32'd667544;
         11: a = 32'd333772;
         12: a = 32'd166886;
         13: a = 32'd83443;
         14: a = 32'd41722;
         15: a = 32'd20861;
         16: a = 32'd10430;
         17: a = 32'd5215;
         18: a = 32'd2608;
         19: a = 32'd1304;
         20: a = 32'd652;
         21: a = 32'd326;
         22: a = 32'd163;
         23: a = 32'd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ----- rtl/petrc_req_if.sv -----
// petrc_req_if: input channel carrying the robot pose and the target position
// valid/ready handshake; no package dependency
interface petrc_req_if #(
   parameter int POS_BITS   = 16,
   parameter int ANGLE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [POS_BITS-1:0]   actual_x;
   logic signed [POS_BITS-1:0]   actual_y;
   logic signed [ANGLE_BITS-1:0] actual_heading;
   logic signed [POS_BITS-1:0]   goal_x;
   logic signed [POS_BITS-1:0]   goal_y;

   modport source (
      output valid, actual_x, actual_y, actual_heading, goal_x, goal_y,
      input  ready
   );
   modport sink (
      input  valid, actual_x, actual_y, actual_heading, goal_x, goal_y,
      output ready
   );
endinterface

// ----- rtl/petrc_rsp_if.sv -----
// petrc_rsp_if: result channel carrying position errors, heading error and reached
// valid/ready handshake; no package dependency
interface petrc_rsp_if #(
   parameter int POS_BITS   = 16,
   parameter int ANGLE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [POS_BITS:0]     error_x;
   logic signed [POS_BITS:0]     error_y;
   logic signed [ANGLE_BITS-1:0] heading_diff;
   logic                         reached;

   modport source (
      output valid, error_x, error_y, heading_diff, reached,
      input  ready
   );
   modport sink (
      input  valid, error_x, error_y, heading_diff, reached,
      output ready
   );
endinterface

// ----- rtl/petrc_csr.sv -----
// petrc_csr: apb-style register block holding the three reach tolerances
// depends on petrc_pkg
module petrc_csr import petrc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output tol_type                  tol
);

   tol_type       tol_ff;
   tol_type       tol_in;
   csr_index_type idx;
   logic          wr_en;

   assign idx    = csr_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign tol    = tol_ff;

   always_comb begin
      tol_in = tol_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_X_TOL: tol_in.x = pwdata[TOL_BITS-1:0];
            CSR_Y_TOL: tol_in.y = pwdata[TOL_BITS-1:0];
            CSR_H_TOL: tol_in.h = pwdata[TOL_BITS-1:0];
            default:   tol_in   = tol_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_X_TOL: prdata = CSR_DATA_BITS'(tol_ff.x);
         CSR_Y_TOL: prdata = CSR_DATA_BITS'(tol_ff.y);
         CSR_H_TOL: prdata = CSR_DATA_BITS'(tol_ff.h);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else begin
         tol_ff <= tol_in;
      end
   end

endmodule

// ----- rtl/petrc_front.sv -----
// petrc_front: first pipeline stage; position errors, x/y tolerance checks and
// the half-plane fold that seeds the cordic; depends on petrc_pkg
module petrc_front import petrc_pkg::*; #(
   parameter int POS_BITS   = 16,
   parameter int ANGLE_BITS = 16,
   parameter int W          = POS_BITS + GUARD_BITS + 3,
   parameter int SW         = 2 * (POS_BITS + 1) + ANGLE_BITS + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [POS_BITS-1:0]   actual_x,
   input  logic signed [POS_BITS-1:0]   actual_y,
   input  logic signed [ANGLE_BITS-1:0] actual_heading,
   input  logic signed [POS_BITS-1:0]   goal_x,
   input  logic signed [POS_BITS-1:0]   goal_y,
   input  tol_type                      tol,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [W-1:0]          out_x,
   output logic signed [W-1:0]          out_y,
   output logic [ZW-1:0]                out_z,
   output logic [SW-1:0]                out_side
);

   localparam int TW = ((POS_BITS > TOL_BITS) ? POS_BITS : TOL_BITS) + 1;

   logic signed [POS_BITS:0] ex;
   logic signed [POS_BITS:0] ey;
   logic signed [POS_BITS:0] ex_neg;
   logic signed [POS_BITS:0] ey_neg;
   logic [POS_BITS-1:0]      abs_x;
   logic [POS_BITS-1:0]      abs_y;
   logic                     xy_ok;
   logic                     zero_vec;
   logic signed [W-1:0]      ex_s;
   logic signed [W-1:0]      ey_s;

   logic                     valid_ff;
   logic signed [W-1:0]      x_ff,    x_in;
   logic signed [W-1:0]      y_ff,    y_in;
   logic [ZW-1:0]            z_ff,    z_in;
   logic [SW-1:0]            side_ff, side_in;

   always_comb begin
      ex       = {actual_x[POS_BITS-1], actual_x} - {goal_x[POS_BITS-1], goal_x};
      ey       = {actual_y[POS_BITS-1], actual_y} - {goal_y[POS_BITS-1], goal_y};
      ex_neg   = -ex;
      ey_neg   = -ey;
      abs_x    = ex[POS_BITS] ? ex_neg[POS_BITS-1:0] : ex[POS_BITS-1:0];
      abs_y    = ey[POS_BITS] ? ey_neg[POS_BITS-1:0] : ey[POS_BITS-1:0];
      xy_ok    = (TW'(abs_x) < TW'(tol.x)) && (TW'(abs_y) < TW'(tol.y));
      zero_vec = (ex == '0) && (ey == '0);
      ex_s     = W'(ex) <<< GUARD_BITS;
      ey_s     = W'(ey) <<< GUARD_BITS;
      // the bearing vector is minus the error; fold it into the right half plane
      if (!ex[POS_BITS] && !zero_vec && (ex != '0)) begin
         x_in = ex_s;
         y_in = ey_s;
         z_in = {1'b1, {(ZW-1){1'b0}}};
      end else begin
         x_in = -ex_s;
         y_in = -ey_s;
         z_in = '0;
      end
      side_in = {ex, ey, actual_heading, xy_ok, zero_vec};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_in;
      end
   end

endmodule

// ----- rtl/petrc_cordic_stage.sv -----
// petrc_cordic_stage: one registered vectoring micro-rotation of the cordic
// depends on petrc_pkg for the arctangent table
module petrc_cordic_stage import petrc_pkg::*; #(
   parameter int W     = 43,
   parameter int SW    = 52,
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [W-1:0] in_x,
   input  logic signed [W-1:0] in_y,
   input  logic [ZW-1:0]       in_z,
   input  logic [SW-1:0]       in_side,
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [W-1:0] out_x,
   output logic signed [W-1:0] out_y,
   output logic [ZW-1:0]       out_z,
   output logic [SW-1:0]       out_side
);

   localparam logic [ZW-1:0] ANGLE = atan_angle(STAGE);

   logic signed [W-1:0] dx;
   logic signed [W-1:0] dy;

   logic                valid_ff;
   logic signed [W-1:0] x_ff,    x_in;
   logic signed [W-1:0] y_ff,    y_in;
   logic [ZW-1:0]       z_ff,    z_in;
   logic [SW-1:0]       side_ff;

   always_comb begin
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      // rotate toward the x axis, direction from the sign of y
      if (!in_y[W-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ANGLE;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ANGLE;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

endmodule

// ----- rtl/petrc_back.sv -----
// petrc_back: last pipeline stage; rounds the bearing, forms the wrapped heading
// error, checks the heading tolerance and holds the result; depends on petrc_pkg
module petrc_back import petrc_pkg::*; #(
   parameter int POS_BITS   = 16,
   parameter int ANGLE_BITS = 16,
   parameter int SW         = 2 * (POS_BITS + 1) + ANGLE_BITS + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [ZW-1:0]                in_z,
   input  logic [SW-1:0]                in_side,
   input  logic [TOL_BITS-1:0]          tol_h,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [POS_BITS:0]     error_x,
   output logic signed [POS_BITS:0]     error_y,
   output logic signed [ANGLE_BITS-1:0] heading_diff,
   output logic                         reached
);

   localparam int HW = ((ANGLE_BITS > TOL_BITS) ? ANGLE_BITS : TOL_BITS) + 1;
   localparam logic [ANGLE_BITS-1:0] H_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};
   localparam logic [ANGLE_BITS-1:0] H_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};

   logic signed [POS_BITS:0]   ex;
   logic signed [POS_BITS:0]   ey;
   logic [ANGLE_BITS-1:0]      heading;
   logic                       xy_ok;
   logic                       zero_vec;
   logic [ZW-1:0]              z_rnd;
   logic [ANGLE_BITS-1:0]      bearing;
   logic [ANGLE_BITS-1:0]      hraw;
   logic [ANGLE_BITS-1:0]      hneg;
   logic [ANGLE_BITS-1:0]      hmag;

   logic                       valid_ff;
   logic signed [POS_BITS:0]   ex_ff;
   logic signed [POS_BITS:0]   ey_ff;
   logic [ANGLE_BITS-1:0]      he_ff;
   logic                       reached_ff, reached_in;

   always_comb begin
      {ex, ey, heading, xy_ok, zero_vec} = in_side;
      z_rnd   = in_z + (ZW'(1) << (31 - ANGLE_BITS));
      bearing = zero_vec ? '0 : z_rnd[ZW-1 -: ANGLE_BITS];
      hraw    = heading - bearing;
      hneg    = -hraw;
      // magnitude saturates at the field maximum for the minus-pi case
      if (hraw == H_MIN) begin
         hmag = H_MAX;
      end else if (hraw[ANGLE_BITS-1]) begin
         hmag = hneg;
      end else begin
         hmag = hraw;
      end
      reached_in = xy_ok && (HW'(hmag) < HW'(tol_h));
   end

   assign in_ready     = !valid_ff || out_ready;
   assign out_valid    = valid_ff;
   assign error_x      = ex_ff;
   assign error_y      = ey_ff;
   assign heading_diff = he_ff;
   assign reached      = reached_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ex_ff      <= ex;
         ey_ff      <= ey;
         he_ff      <= hraw;
         reached_ff <= reached_in;
      end
   end

endmodule

// ----- rtl/pose_error_target_reach_check.sv -----
// pose_error_target_reach_check: pose errors, cordic bearing and reach flag
// pipeline stages: front stage, one stage per cordic micro-rotation, and a result
// register; one item per cycle while the result channel does not hold off the flow
// every stage stalls on its own full register, so bubbles fill in under backpressure
// synchronous active-high reset empties the pipeline and clears the tolerances to 0
module pose_error_target_reach_check import petrc_pkg::*; #(
   parameter int POS_BITS      = 16,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   petrc_req_if.sink                req_ch,
   petrc_rsp_if.source              rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int W  = POS_BITS + GUARD_BITS + 3;
   localparam int SW = 2 * (POS_BITS + 1) + ANGLE_BITS + 2;

   tol_type             tol;

   logic                st_valid [0:CORDIC_STAGES];
   logic                st_ready [0:CORDIC_STAGES];
   logic signed [W-1:0] st_x     [0:CORDIC_STAGES];
   logic signed [W-1:0] st_y     [0:CORDIC_STAGES];
   logic [ZW-1:0]       st_z     [0:CORDIC_STAGES];
   logic [SW-1:0]       st_side  [0:CORDIC_STAGES];

   petrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .tol     (tol)
   );

   petrc_front #(
      .POS_BITS   (POS_BITS),
      .ANGLE_BITS (ANGLE_BITS),
      .W          (W),
      .SW         (SW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_ch.valid),
      .in_ready       (req_ch.ready),
      .actual_x       (req_ch.actual_x),
      .actual_y       (req_ch.actual_y),
      .actual_heading (req_ch.actual_heading),
      .goal_x         (req_ch.goal_x),
      .goal_y         (req_ch.goal_y),
      .tol            (tol),
      .out_valid      (st_valid[0]),
      .out_ready      (st_ready[0]),
      .out_x          (st_x[0]),
      .out_y          (st_y[0]),
      .out_z          (st_z[0]),
      .out_side       (st_side[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      petrc_cordic_stage #(
         .W     (W),
         .SW    (SW),
         .STAGE (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[i]),
         .in_ready  (st_ready[i]),
         .in_x      (st_x[i]),
         .in_y      (st_y[i]),
         .in_z      (st_z[i]),
         .in_side   (st_side[i]),
         .out_valid (st_valid[i+1]),
         .out_ready (st_ready[i+1]),
         .out_x     (st_x[i+1]),
         .out_y     (st_y[i+1]),
         .out_z     (st_z[i+1]),
         .out_side  (st_side[i+1])
      );
   end

   // the last stage's x holds the gain-scaled vector magnitude and y the residual; nothing needs them
   petrc_back #(
      .POS_BITS   (POS_BITS),
      .ANGLE_BITS (ANGLE_BITS),
      .SW         (SW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (st_valid[CORDIC_STAGES]),
      .in_ready     (st_ready[CORDIC_STAGES]),
      .in_z         (st_z[CORDIC_STAGES]),
      .in_side      (st_side[CORDIC_STAGES]),
      .tol_h        (tol.h),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .error_x      (rsp_ch.error_x),
      .error_y      (rsp_ch.error_y),
      .heading_diff (rsp_ch.heading_diff),
      .reached      (rsp_ch.reached)
   );

endmodule

// ----- rtl/petrc_checker.sv -----
// petrc_checker: port-level assertions for pose_error_target_reach_check
// bound to the top level below; depends on petrc_pkg
module petrc_checker import petrc_pkg::*; #(
   parameter int POS_BITS = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [POS_BITS:0] rsp_error_x,
   input logic                     rsp_reached,
   input logic                     csr_psel,
   input logic                     csr_penable,
   input logic                     csr_pwrite,
   input logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input logic                     csr_pready
);

   localparam int CW = POS_BITS + TOL_BITS + 1;

   logic [7:0]          pending_ff, pending_in;
   logic [TOL_BITS-1:0] xtol_ff,    xtol_in;
   logic signed [POS_BITS:0] err_neg;
   logic [POS_BITS:0]   abs_x;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + 8'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 8'd1;
      end
      xtol_in = xtol_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && (csr_index_type'(csr_paddr[3:2]) == CSR_X_TOL)) begin
         xtol_in = csr_pwdata[TOL_BITS-1:0];
      end
      err_neg = -rsp_error_x;
      abs_x   = rsp_error_x[POS_BITS] ? err_neg : rsp_error_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         xtol_ff    <= '0;
      end else begin
         pending_ff <= pending_in;
         xtol_ff    <= xtol_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("result item with no item in flight");

   a_reached_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reached |-> (CW'(abs_x) < CW'(xtol_ff)))
      else $error("reached set with x error at or above tolerance");

endmodule

bind pose_error_target_reach_check petrc_checker #(
   .POS_BITS (POS_BITS)
) u_petrc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_error_x (rsp_ch.error_x),
   .rsp_reached (rsp_ch.reached),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_pready  (csr_pready)
);
